@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of the line mask filter.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dlm_pkg.sv @@
// Package of the diagonal line mask filter: sizes, coefficients, register
// codes and the request payload types. Depends on nothing.
package dlm_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int COL_W          = $clog2(MAX_WIDTH);
    localparam int ROW_W          = 13;
    localparam int HEIGHT_LIMIT   = 4096;
    localparam int SIZE_MIN       = 3;
    localparam int WIDTH_RESET    = 640;
    localparam int HEIGHT_RESET   = 480;
    localparam int WIDTH_FIELD_W  = 11;
    localparam int HEIGHT_FIELD_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int REG_IDX_W      = 1;
    localparam int PIX_W          = 8;
    localparam int OUT_COL_W      = 10;
    localparam int OUT_ROW_W      = 12;

    // Q0.8 luma weights
    localparam int GRAY_R_COEF = 54;
    localparam int GRAY_G_COEF = 182;
    localparam int GRAY_B_COEF = 18;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             pad;
    } pix_t;

    typedef struct packed {
        logic [PIX_W-1:0]     out_gray;
        logic [OUT_COL_W-1:0] out_col;
        logic [OUT_ROW_W-1:0] out_row;
        logic                 frame_last;
    } res_t;

endpackage

@@ rtl/dlm_ifs.sv @@
// Valid/ready channel interfaces for pixel requests and result requests.
// Depends on dlm_pkg for the payload types.
interface dlm_pix_if;
    import dlm_pkg::*;
    logic valid;
    logic ready;
    pix_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dlm_res_if;
    import dlm_pkg::*;
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/dlm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. Depends on nothing.
module dlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/diagonal_line_mask_filter_top.sv @@
// Top level of the 3x3 diagonal line mask filter on an RGB raster stream.
// Depends on dlm_pkg, dlm_ifs (channel interfaces) and dlm_ram (line stores).
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+--------------------------------------
//   pixel     | in  | valid/ready   | red, green, blue, pad
//   result    | out | valid/ready   | out_gray, out_col, out_row, frame_last
//   cfg       | in  | cfg_we only   | cfg_index, cfg_data
//
// One pixel request per cycle sustained while results are taken; a request
// passes three register stages (gray convert, window step, mask and
// saturate), and the last of them holds the result for the result channel.
// The window step reads both line stores ahead at the next column,
// so one read and one write per store per cycle set the rate.
// Reset clears counters, taps and valids, and sets the sizes to 640 x 480.
// Stalls on the result side back up stage by stage; requests that make no
// result fill no later stage; ready drops once every stage holds a request.
module diagonal_line_mask_filter_top (
    input  logic                             clk,
    input  logic                             rst_n,
    dlm_pix_if.sink                          pixel,
    dlm_res_if.source                        result,
    input  logic                             cfg_we,
    input  logic [dlm_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [dlm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import dlm_pkg::*;

    // Payload of the window stage, handed to the mask stage.
    typedef struct packed {
        logic                 border;
        logic                 last;
        logic [PIX_W-1:0]     bval;
        logic [PIX_W+1:0]     diag;     // sum of the three diagonal taps
        logic [PIX_W+2:0]     others;   // sum of the six off-diagonal taps
        logic [COL_W-1:0]     ox;
        logic [ROW_W-1:0]     oy;
    } win_t;

    // ------------------------------------------------------------------
    // Size registers: clamped on write, kept as W-1 and H.
    // ------------------------------------------------------------------
    logic [COL_W-1:0]          wm1_reg, wm1_next;
    logic [ROW_W-1:0]          h_reg, h_next;
    logic                      restart;
    logic [WIDTH_FIELD_W-1:0]  wv;
    logic [HEIGHT_FIELD_W-1:0] hv;

    assign wv = cfg_data[WIDTH_FIELD_W-1:0];
    assign hv = cfg_data[HEIGHT_FIELD_W-1:0];

    always_comb
    begin
        wm1_next = wm1_reg;
        h_next   = h_reg;
        restart  = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    restart = 1'b1;
                    if (32'(wv) < SIZE_MIN)
                        wm1_next = COL_W'(SIZE_MIN - 1);
                    else if (32'(wv) > MAX_WIDTH)
                        wm1_next = COL_W'(MAX_WIDTH - 1);
                    else
                        wm1_next = COL_W'(wv - WIDTH_FIELD_W'(1));
                end
                REG_IMAGE_HEIGHT:
                begin
                    restart = 1'b1;
                    if (32'(hv) < SIZE_MIN)
                        h_next = ROW_W'(SIZE_MIN);
                    else if (32'(hv) > HEIGHT_LIMIT)
                        h_next = ROW_W'(HEIGHT_LIMIT);
                    else
                        h_next = ROW_W'(hv);
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: each stage moves when the one after it is empty or moving.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic res_valid_reg, res_valid_next;
    logic s3_free, s2_free, s1_free, step;

    assign s3_free = !res_valid_reg || result.ready;
    assign s2_free = !s2_valid_reg || s3_free;
    assign s1_free = !s1_valid_reg || s2_free;
    assign step    = s1_valid_reg && s2_free;

    assign pixel.ready = s1_free;

    // ------------------------------------------------------------------
    // Stage 1: gray conversion. Max sum is 64770, so gray never passes 253.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] s1_gray_reg, s1_gray_next;
    logic             s1_pad_reg, s1_pad_next;
    logic [15:0]      gray_sum;

    assign gray_sum = 16'(GRAY_R_COEF) * 16'(pixel.data.red)
                    + 16'(GRAY_G_COEF) * 16'(pixel.data.green)
                    + 16'(GRAY_B_COEF) * 16'(pixel.data.blue);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_gray_next  = s1_gray_reg;
        s1_pad_next   = s1_pad_reg;
        if (s1_free)
        begin
            s1_valid_next = pixel.valid;
            s1_gray_next  = gray_sum[15:8];
            s1_pad_next   = pixel.data.pad;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: window step. Read both line stores at the column, shift the
    // taps, write back the column, advance the raster position.
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [PIX_W-1:0] tap_reg [3][2];   // [row oldest..newest][older, newest]
    logic [PIX_W-1:0] tap_next [3][2];
    logic [PIX_W-1:0] up_rd, mid_rd, g;
    logic             taking, live, emit_in, emit_edge, emit;
    win_t             win_reg, win_next, win_step;

    assign taking    = row_reg < h_reg;
    // drop pad requests while pixels are still expected
    assign live      = step && !(s1_pad_reg && taking);
    assign g         = taking ? s1_gray_reg : '0;
    assign emit_in   = (col_reg != '0) && (row_reg != '0);
    assign emit_edge = (col_reg == '0) && (row_reg >= ROW_W'(2));
    assign emit      = emit_in || emit_edge;

    // All border cases read the newest middle-row tap before the shift.
    always_comb
    begin
        win_step.border = emit_edge || (col_reg == COL_W'(1))
                        || (row_reg == ROW_W'(1)) || (row_reg == h_reg);
        win_step.last   = emit_edge && (row_reg == h_reg + ROW_W'(1));
        win_step.bval   = tap_reg[1][1];
        win_step.diag   = (PIX_W+2)'(tap_reg[2][0]) + (PIX_W+2)'(tap_reg[1][1])
                        + (PIX_W+2)'(up_rd);
        win_step.others = (PIX_W+3)'(tap_reg[0][0]) + (PIX_W+3)'(tap_reg[0][1])
                        + (PIX_W+3)'(tap_reg[1][0]) + (PIX_W+3)'(mid_rd)
                        + (PIX_W+3)'(tap_reg[2][1]) + (PIX_W+3)'(g);
        win_step.ox     = emit_edge ? wm1_reg : col_reg - COL_W'(1);
        win_step.oy     = emit_edge ? row_reg - ROW_W'(2) : row_reg - ROW_W'(1);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        for (int i = 0; i < 3; i++)
        begin
            tap_next[i][0] = tap_reg[i][0];
            tap_next[i][1] = tap_reg[i][1];
        end
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
            for (int i = 0; i < 3; i++)
            begin
                tap_next[i][0] = '0;
                tap_next[i][1] = '0;
            end
        end
        else if (live)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tap_next[i][0] = tap_reg[i][1];
            end
            tap_next[0][1] = up_rd;
            tap_next[1][1] = mid_rd;
            tap_next[2][1] = g;
            if (emit && win_step.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_reg == wm1_reg)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        win_next      = win_reg;
        if (s2_free)
        begin
            s2_valid_next = live && emit;
            win_next      = win_step;
        end
    end

    // Line stores: read ahead at the column the next step will use.
    // The write in a step targets the column just left, so it misses the
    // prefetch, except at frame end: column 0 is written and reread at once
    // and the old word comes back. That word only reaches row 0 taps and the
    // upper taps of row 1, whose windows emit nothing or a border value.
    dlm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_ram (
        .clk   (clk),
        .we    (live),
        .waddr (col_reg),
        .wdata (mid_rd),
        .raddr (col_next),
        .rdata (up_rd)
    );

    dlm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_ram (
        .clk   (clk),
        .we    (live),
        .waddr (col_reg),
        .wdata (g),
        .raddr (col_next),
        .rdata (mid_rd)
    );

    // ------------------------------------------------------------------
    // Stage 3: apply mask 2*diag - others, saturate to 0..255, register out.
    // ------------------------------------------------------------------
    logic [PIX_W+4:0] mask_diff;
    logic [PIX_W-1:0] mask_val;
    res_t             res_reg, res_next;

    assign mask_diff = {2'b00, win_reg.diag, 1'b0} - {2'b00, win_reg.others};

    always_comb
    begin
        if (mask_diff[PIX_W+4])
            mask_val = '0;
        else if (mask_diff[PIX_W+3:PIX_W] != '0)
            mask_val = '1;
        else
            mask_val = mask_diff[PIX_W-1:0];
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (s3_free)
        begin
            res_valid_next      = s2_valid_reg;
            res_next.out_gray   = win_reg.border ? win_reg.bval : mask_val;
            res_next.out_col    = OUT_COL_W'(win_reg.ox);
            res_next.out_row    = OUT_ROW_W'(win_reg.oy);
            res_next.frame_last = win_reg.last;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wm1_reg       <= COL_W'(WIDTH_RESET - 1);
            h_reg         <= ROW_W'(HEIGHT_RESET);
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            for (int i = 0; i < 3; i++)
            begin
                tap_reg[i][0] <= '0;
                tap_reg[i][1] <= '0;
            end
        end
        else
        begin
            wm1_reg       <= wm1_next;
            h_reg         <= h_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            res_valid_reg <= res_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            for (int i = 0; i < 3; i++)
            begin
                tap_reg[i][0] <= tap_next[i][0];
                tap_reg[i][1] <= tap_next[i][1];
            end
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        s1_gray_reg <= s1_gray_next;
        s1_pad_reg  <= s1_pad_next;
        win_reg     <= win_next;
        res_reg     <= res_next;
    end

endmodule

@@ rtl/dlm_checker.sv @@
// Port-level checker for the line mask filter top, bound into it below.
// Depends on dlm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dlm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [dlm_pkg::PIX_W-1:0]        out_gray,
    input logic [dlm_pkg::OUT_COL_W-1:0]    out_col,
    input logic [dlm_pkg::OUT_ROW_W-1:0]    out_row,
    input logic                             out_last,
    input logic                             cfg_we
);

    import dlm_pkg::*;

    logic                 out_fire;
    logic                 first_reg, first_next;
    logic [OUT_COL_W-1:0] prev_col_reg, prev_col_next;
    logic [OUT_ROW_W-1:0] prev_row_reg, prev_row_next;

    assign out_fire = out_valid && out_ready;

    // Track the previous result position; a frame restarts after the last
    // pixel or a register write.
    always_comb
    begin
        first_next    = first_reg;
        prev_col_next = prev_col_reg;
        prev_row_next = prev_row_reg;
        if (cfg_we)
        begin
            first_next = 1'b1;
        end
        else if (out_fire)
        begin
            first_next    = out_last;
            prev_col_next = out_col;
            prev_row_next = out_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg    <= 1'b1;
            prev_col_reg <= '0;
            prev_row_reg <= '0;
        end
        else
        begin
            first_reg    <= first_next;
            prev_col_reg <= prev_col_next;
            prev_row_reg <= prev_row_next;
        end
    end

    `DLM_ASSERT_NEXT(a_result_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_gray) && $stable(out_col) && $stable(out_row) && $stable(out_last), "result request changed while stalled")

    `DLM_ASSERT_NOW(a_frame_start, clk, rst_n, out_fire && first_reg, out_col == '0 && out_row == '0, "frame did not start at the top left pixel")

    `DLM_ASSERT_NOW(a_raster_order, clk, rst_n, out_fire && !first_reg, (out_row == prev_row_reg && out_col == prev_col_reg + OUT_COL_W'(1)) || (out_row == prev_row_reg + OUT_ROW_W'(1) && out_col == '0), "results left raster order")

    `DLM_ASSERT_NOW(a_last_corner, clk, rst_n, out_valid && out_last, out_col != '0 && out_row != '0, "frame end flagged away from the bottom right")

endmodule

bind diagonal_line_mask_filter_top dlm_checker u_dlm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_gray  (result.data.out_gray),
    .out_col   (result.data.out_col),
    .out_row   (result.data.out_row),
    .out_last  (result.data.frame_last),
    .cfg_we    (cfg_we)
);
